### hdl/hrfe_pkg.sv
`default_nettype none

package hrfe_pkg;

  localparam int unsigned PosW = 16;

  typedef logic [PosW-1:0] pos_t;

  localparam pos_t PosMax = '1;

  localparam logic [31:0] PatGet  = 32'h4745_5420;
  localparam logic [31:0] PatPost = 32'h504F_5354;
  localparam logic [47:0] PatHttp = 48'h2048_5454_502F;
  localparam logic [31:0] PatHost = 32'h486F_7374;
  localparam logic [15:0] PatCrlf = 16'h0D0A;

  localparam logic [15:0] MinRequestReset = 16'd200;
  localparam logic [15:0] MinHostReset    = 16'd15;

  localparam logic [2:0] UriOffNone = 3'd0;
  localparam logic [2:0] UriOffGet  = 3'd4;
  localparam logic [2:0] UriOffPost = 3'd5;

  localparam pos_t HostSkip = pos_t'(6);

  typedef enum logic [0:0] {
    RegMinRequest = 1'b0,
    RegMinHost    = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MethodNone = 2'd0,
    MethodGet  = 2'd1,
    MethodPost = 2'd2
  } method_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } stage_t;

  typedef struct packed {
    pos_t        count;
    logic [31:0] lead;
    logic        uri_found;
    pos_t        uri_pos;
    logic        host_found;
    pos_t        host_pos;
    logic        host_end_found;
    pos_t        host_end_pos;
  } scan_t;

  function automatic logic [2:0] uri_start(input logic [31:0] word);
    logic [2:0] s;
    if (word == PatGet) begin
      s = UriOffGet;
    end else if (word == PatPost) begin
      s = UriOffPost;
    end else begin
      s = UriOffNone;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

### hdl/hrfe_in_if.sv
`default_nettype none

interface hrfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

### hdl/hrfe_out_if.sv
`default_nettype none

interface hrfe_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  method;
  logic [2:0]  uri_offset;
  logic [15:0] uri_length;
  logic [15:0] host_offset;
  logic [15:0] host_length;

  modport source (
    output valid, output method, output uri_offset, output uri_length,
    output host_offset, output host_length, input ready
  );
  modport sink (
    input valid, input method, input uri_offset, input uri_length,
    input host_offset, input host_length, output ready
  );
endinterface

`default_nettype wire

### hdl/hrfe_input_reg.sv
`default_nettype none

module hrfe_input_reg
  import hrfe_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  hrfe_in_if.sink     payload,
  input  wire logic   advance,
  output stage_t      stage
);

  assign payload.ready = !stage.valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (payload.valid && payload.ready) begin
      stage.valid <= 1'b1;
    end else if (advance) begin
      stage.valid <= 1'b0;
    end
    if (payload.valid && payload.ready) begin
      stage.data <= payload.data_byte;
      stage.last <= payload.last_byte;
    end
  end

endmodule

`default_nettype wire

### hdl/hrfe_scanner.sv
`default_nettype none

module hrfe_scanner
  import hrfe_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire stage_t stage,
  input  wire logic   advance,
  output scan_t       scan_next
);

  scan_t       scan;
  logic [47:0] recent;
  logic [47:0] recent_next;
  logic        update;
  logic [2:0]  start;
  pos_t        uri_cand;
  pos_t        end_cand;
  logic        uri_hit;
  logic        host_hit;
  logic        end_hit;

  assign update      = (scan.count != PosMax);
  assign recent_next = {recent[39:0], stage.data};
  assign start       = uri_start(scan.lead);
  assign uri_cand    = scan.count - pos_t'(5);
  assign end_cand    = scan.count - pos_t'(1);

  assign uri_hit = (scan.count >= pos_t'(5)) && !scan.uri_found && (recent_next == PatHttp)
                   && (start != UriOffNone) && (uri_cand >= pos_t'(start));
  assign host_hit = (scan.count >= pos_t'(3)) && !scan.host_found
                    && (recent_next[31:0] == PatHost);
  assign end_hit = (scan.count >= pos_t'(1)) && scan.host_found && !scan.host_end_found
                   && (recent_next[15:0] == PatCrlf)
                   && ({1'b0, end_cand} >= ({1'b0, scan.host_pos} + {1'b0, HostSkip}));

  always_comb begin
    scan_next = scan;
    if (update) begin
      scan_next.count = scan.count + pos_t'(1);
      if (scan.count < pos_t'(4)) begin
        scan_next.lead = {scan.lead[23:0], stage.data};
      end
      if (uri_hit) begin
        scan_next.uri_found = 1'b1;
        scan_next.uri_pos   = uri_cand;
      end
      if (host_hit) begin
        scan_next.host_found = 1'b1;
        scan_next.host_pos   = scan.count - pos_t'(3);
      end
      if (end_hit) begin
        scan_next.host_end_found = 1'b1;
        scan_next.host_end_pos   = end_cand;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan   <= '0;
      recent <= '0;
    end else if (advance && stage.valid) begin
      if (stage.last) begin
        scan   <= '0;
        recent <= '0;
      end else begin
        scan <= scan_next;
        if (update) begin
          recent <= recent_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

### hdl/hrfe_result.sv
`default_nettype none

module hrfe_result
  import hrfe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        fire,
  input  wire scan_t       scan_next,
  input  wire logic [15:0] min_request_length,
  input  wire logic [15:0] min_host_length,
  output logic             advance,
  hrfe_out_if.source       result
);

  pos_t            len;
  logic [2:0]      start;
  logic            req_ok;
  logic [PosW:0]   value_start;
  logic            host_ok;
  method_t         method_next;
  logic [2:0]      uri_offset_next;
  pos_t            uri_length_next;
  pos_t            host_offset_next;
  pos_t            host_length_next;

  assign advance = !result.valid || result.ready;

  assign len         = scan_next.count;
  assign start       = uri_start(scan_next.lead);
  assign req_ok      = (len >= pos_t'(min_request_length)) && (len >= pos_t'(4))
                       && (start != UriOffNone);
  assign value_start = {1'b0, scan_next.host_pos} + {1'b0, HostSkip};
  assign host_ok     = (len >= pos_t'(min_host_length)) && scan_next.host_found
                       && (scan_next.host_pos != '0) && (value_start < {1'b0, len});

  always_comb begin
    method_next      = MethodNone;
    uri_offset_next  = UriOffNone;
    uri_length_next  = '0;
    host_offset_next = '0;
    host_length_next = '0;
    if (req_ok) begin
      method_next     = (start == UriOffGet) ? MethodGet : MethodPost;
      uri_offset_next = start;
      if (scan_next.uri_found) begin
        uri_length_next = scan_next.uri_pos - pos_t'(start);
      end
    end
    if (host_ok) begin
      host_offset_next = value_start[PosW-1:0];
      if (scan_next.host_end_found) begin
        host_length_next = scan_next.host_end_pos - value_start[PosW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (fire) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.method      <= method_next;
      result.uri_offset  <= uri_offset_next;
      result.uri_length  <= 16'(uri_length_next);
      result.host_offset <= 16'(host_offset_next);
      result.host_length <= 16'(host_length_next);
    end
  end

endmodule

`default_nettype wire

### hdl/http_request_field_extractor_core.sv
`default_nettype none

// Scans one packet's payload, one byte per transfer, and on the transfer that
// carries the last-byte mark delivers one result with the request method, the
// URI offset and length, and the offset and length of the Host value. The
// block takes one byte every clock cycle with no gaps while no result is
// stalled; a byte register feeds a scan stage whose result register takes
// the finished fields once the last byte leaves the byte register. Matching
// state is held in a few position registers and a six-byte window, so packet
// length is not limited except that positions stop counting at 65535 bytes.
// The user must write the two length thresholds through the configuration
// port between packets, unchecked by the block. They reset to 200 and 15.
module http_request_field_extractor_core
  import hrfe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  hrfe_in_if.sink          payload,
  hrfe_out_if.source       result
);

  logic [15:0] min_request_length;
  logic [15:0] min_host_length;
  stage_t      stage;
  scan_t       scan_next;
  logic        advance;
  logic        fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_request_length <= MinRequestReset;
      min_host_length    <= MinHostReset;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        RegMinRequest: min_request_length <= cfg_data;
        RegMinHost:    min_host_length    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign fire = advance && stage.valid && stage.last;

  hrfe_input_reg u_input_reg (
    .clk     (clk),
    .rst     (rst),
    .payload (payload),
    .advance (advance),
    .stage   (stage)
  );

  hrfe_scanner u_scanner (
    .clk       (clk),
    .rst       (rst),
    .stage     (stage),
    .advance   (advance),
    .scan_next (scan_next)
  );

  hrfe_result u_result (
    .clk                (clk),
    .rst                (rst),
    .fire               (fire),
    .scan_next          (scan_next),
    .min_request_length (min_request_length),
    .min_host_length    (min_host_length),
    .advance            (advance),
    .result             (result)
  );

endmodule

`default_nettype wire

### hdl/hrfe_checker.sv
`default_nettype none

module hrfe_checker
  import hrfe_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  method,
  input wire logic [2:0]  uri_offset,
  input wire logic [15:0] uri_length,
  input wire logic [15:0] host_offset,
  input wire logic [15:0] host_length
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(method) && $stable(uri_offset)
      && $stable(uri_length) && $stable(host_offset) && $stable(host_length))
    else $error("Stalled result changed before its transfer.");

  a_method_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (method == MethodNone && uri_offset == UriOffNone && uri_length == 16'd0)
      || (method == MethodGet && uri_offset == UriOffGet)
      || (method == MethodPost && uri_offset == UriOffPost))
    else $error("Method and URI fields disagree.");

  a_host_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && host_offset == 16'd0 |-> host_length == 16'd0)
    else $error("Host length given without a host offset.");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("Result offered right after reset.");

endmodule

bind http_request_field_extractor_core hrfe_checker u_hrfe_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .method      (result.method),
  .uri_offset  (result.uri_offset),
  .uri_length  (result.uri_length),
  .host_offset (result.host_offset),
  .host_length (result.host_length)
);

`default_nettype wire

### dv/tb_http_request_field_extractor_core.sv
`default_nettype none

module tb_http_request_field_extractor_core;
  import hrfe_pkg::*;

  localparam logic [31:0] GET_WORD  = "GET ";
  localparam logic [31:0] POST_WORD = "POST";
  localparam logic [47:0] HTTP_MARK = " HTTP/";
  localparam logic [31:0] HOST_MARK = "Host";
  localparam logic [15:0] CRLF_MARK = "\r\n";
  localparam logic [15:0] POS_LIMIT = 16'hFFFF;

  typedef struct packed {
    method_t     method;
    logic [2:0]  uri_offset;
    logic [15:0] uri_length;
    logic [15:0] host_offset;
    logic [15:0] host_length;
  } req_fields_t;

  localparam req_fields_t NO_FIELDS = '0;

  typedef struct {
    logic [15:0] req_min;
    logic [15:0] host_min;
    string       text;
    bit          pinned;
    req_fields_t want;
  } probe_t;

  probe_t probes [20] = '{
    '{16'd200, 16'd15, "GET / HTTP/1.1\r\n\r\n", 1'b1, NO_FIELDS},
    '{16'd200, 16'd15, "X", 1'b1, NO_FIELDS},
    '{16'd0, 16'd0, "GET / HTTP/1.1\r\nHost: ab\r\n\r\n", 1'b1,
      '{MethodGet, 3'd4, 16'd1, 16'd22, 16'd2}},
    '{16'd0, 16'd0, "GET", 1'b1, NO_FIELDS},
    '{16'd0, 16'd0, "POST", 1'b1, '{MethodPost, 3'd5, 16'd0, 16'd0, 16'd0}},
    '{16'd0, 16'd0, "GET  HTTP/1.0", 1'b1, '{MethodGet, 3'd4, 16'd0, 16'd0, 16'd0}},
    '{16'd0, 16'd0, "GET HTTP/1.0 HTTP/1.1", 1'b0, NO_FIELDS},
    '{16'd0, 16'd0, "POST /up HTTP/1.1\r\nHost: h\r\n", 1'b0, NO_FIELDS},
    '{16'd0, 16'd0, "GET /no-version\r\nHost: x", 1'b0, NO_FIELDS},
    '{16'd0, 16'd0, "Host: a\r\n", 1'b1, NO_FIELDS},
    '{16'd0, 16'd0, "xHost:", 1'b1, NO_FIELDS},
    '{16'd0, 16'd0, "xHost: ", 1'b1, NO_FIELDS},
    '{16'd0, 16'd0, "xHost: a", 1'b1, '{MethodNone, 3'd0, 16'd0, 16'd7, 16'd0}},
    '{16'd0, 16'd0, "xHost: \r\n", 1'b1, '{MethodNone, 3'd0, 16'd0, 16'd7, 16'd0}},
    '{16'd0, 16'd0, "\r\nHost: b\r\nHost: c\r\n", 1'b0, NO_FIELDS},
    '{16'd0, 16'd0, "get / HTTP/1.1", 1'b1, NO_FIELDS},
    '{16'd0, 16'd0, "POST  HTTP/", 1'b0, NO_FIELDS},
    '{16'hFFFF, 16'hFFFF, "GET / HTTP/1.1\r\nHost: a\r\n", 1'b1, NO_FIELDS},
    '{16'd26, 16'd25, "GET / HTTP/1.1\r\nHost: ab\r\n", 1'b0, NO_FIELDS},
    '{16'd27, 16'd27, "GET / HTTP/1.1\r\nHost: ab\r\n", 1'b1, NO_FIELDS}
  };

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;

  hrfe_in_if  payload_if ();
  hrfe_out_if result_if ();

  http_request_field_extractor_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .payload(payload_if.sink),
    .result(result_if.source)
  );

  logic [15:0] req_min = 16'd200;
  logic [15:0] host_min = 16'd15;
  logic [15:0] scan_pos = '0;
  logic [47:0] window = '0;
  logic [31:0] lead = '0;
  bit          uri_hit = 1'b0;
  logic [15:0] uri_at = '0;
  bit          host_hit = 1'b0;
  logic [15:0] host_at = '0;
  bit          crlf_hit = 1'b0;
  logic [15:0] crlf_at = '0;

  req_fields_t fields_q [$];
  req_fields_t pinned_fields;
  bit          pin_next = 1'b0;

  logic [7:0]  pkt_bytes [$];
  string       uri_chars = "abcdefghijklmnopqrstuvwxyz0123456789/._-?=%";
  string       short_chars = "GETPOSTHost \r\n/";

  int fail_count = 0;
  int bytes_accepted = 0;
  int packets_sent = 0;
  int results_checked = 0;
  int method_seen = 0;
  int host_seen = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;

  int rx_left = 0;
  int rx_mode = 0;
  int hold_left = 0;
  bit hold_armed = 1'b0;
  bit hold_taken = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_http_request_field_extractor_core: errors");
    $finish;
  end

  function automatic void track_byte(input logic [7:0] b, input logic last);
    int unsigned n;
    int unsigned s;
    int unsigned v;
    int unsigned len;
    req_fields_t r;
    if (scan_pos != POS_LIMIT) begin
      n = scan_pos;
      window = {window[39:0], b};
      if (n < 4) lead = {lead[23:0], b};
      if (n >= 5 && !uri_hit && window == HTTP_MARK) begin
        s = (lead == GET_WORD) ? 4 : (lead == POST_WORD) ? 5 : 0;
        if (s != 0 && n - 5 >= s) begin
          uri_hit = 1'b1;
          uri_at = 16'(n - 5);
        end
      end
      if (n >= 3 && !host_hit && window[31:0] == HOST_MARK) begin
        host_hit = 1'b1;
        host_at = 16'(n - 3);
      end
      if (n >= 1 && host_hit && !crlf_hit && window[15:0] == CRLF_MARK &&
          n - 1 >= int'(host_at) + 6) begin
        crlf_hit = 1'b1;
        crlf_at = 16'(n - 1);
      end
      scan_pos = 16'(n + 1);
    end
    if (last) begin
      r = NO_FIELDS;
      len = scan_pos;
      if (len >= req_min && len >= 4) begin
        if (lead == GET_WORD) begin
          r.method = MethodGet;
          r.uri_offset = 3'd4;
          if (uri_hit) r.uri_length = uri_at - 16'd4;
        end else if (lead == POST_WORD) begin
          r.method = MethodPost;
          r.uri_offset = 3'd5;
          if (uri_hit) r.uri_length = uri_at - 16'd5;
        end
      end
      if (len >= host_min && host_hit && host_at != 0) begin
        v = int'(host_at) + 6;
        if (v < len) begin
          r.host_offset = 16'(v);
          if (crlf_hit) r.host_length = 16'(crlf_at - v);
        end
      end
      if (pin_next) begin
        fields_q.push_back(pinned_fields);
        pin_next = 1'b0;
      end else begin
        fields_q.push_back(r);
      end
      scan_pos = '0;
      window = '0;
      lead = '0;
      uri_hit = 1'b0;
      uri_at = '0;
      host_hit = 1'b0;
      host_at = '0;
      crlf_hit = 1'b0;
      crlf_at = '0;
    end
  endfunction

  always @(posedge clk) begin : monitor
    req_fields_t got;
    req_fields_t want;
    if (!rst) begin
      if (payload_if.valid && payload_if.ready) begin
        bytes_accepted++;
        track_byte(payload_if.data_byte, payload_if.last_byte);
      end
      if (result_if.valid && result_if.ready) begin
        got.method = method_t'(result_if.method);
        got.uri_offset = result_if.uri_offset;
        got.uri_length = result_if.uri_length;
        got.host_offset = result_if.host_offset;
        got.host_length = result_if.host_length;
        results_checked++;
        if (got.method != MethodNone) method_seen++;
        if (got.host_offset != 0) host_seen++;
        if (fields_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result with none expected: method %0d uri %0d+%0d host %0d+%0d",
                     $realtime, got.method, got.uri_offset, got.uri_length,
                     got.host_offset, got.host_length);
          fail_count++;
        end else begin
          want = fields_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display({"%0t: mismatch: method %0d/%0d uri_offset %0d/%0d uri_length %0d/%0d",
                        " host_offset %0d/%0d host_length %0d/%0d (expected/actual)"},
                       $realtime, want.method, got.method, want.uri_offset, got.uri_offset,
                       want.uri_length, got.uri_length, want.host_offset, got.host_offset,
                       want.host_length, got.host_length);
            fail_count++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_armed && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = 300;
    end
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(50, 400);
    end else begin
      rx_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_if.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: result_if.ready <= 1'b1;
        1: result_if.ready <= 1'($urandom_range(0, 1));
        default: result_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) pkt_bytes.push_back(s[i]);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(1, 6);
      payload_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    payload_if.valid <= 1'b1;
    payload_if.data_byte <= b;
    payload_if.last_byte <= last;
    @(posedge clk);
    while (!payload_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_bytes.size(); i++) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    packets_sent++;
  endtask

  task automatic drain();
    payload_if.valid <= 1'b0;
    while (fields_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_thresholds(input logic [15:0] req_len, input logic [15:0] host_len);
    cfg_we <= 1'b1;
    cfg_index <= RegMinRequest;
    cfg_data <= req_len;
    @(negedge clk);
    cfg_index <= RegMinHost;
    cfg_data <= host_len;
    @(negedge clk);
    cfg_we <= 1'b0;
    req_min = req_len;
    host_min = host_len;
  endtask

  initial begin : stimulus
    int n;
    int kind;
    int phase_bytes;
    int phase_pkts;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = RegMinRequest;
    cfg_data = '0;
    payload_if.valid = 1'b0;
    payload_if.data_byte = '0;
    payload_if.last_byte = 1'b0;
    result_if.ready = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (probes[i]) begin
      if (probes[i].req_min != req_min || probes[i].host_min != host_min) begin
        drain();
        set_thresholds(probes[i].req_min, probes[i].host_min);
      end
      pin_next = probes[i].pinned;
      pinned_fields = probes[i].want;
      pkt_bytes.delete();
      add_text(probes[i].text);
      send_packet();
    end

    drain();
    set_thresholds(16'd0, 16'd0);
    pkt_bytes = '{8'h00, 8'hFF, 8'h00, 8'hFF};
    send_packet();
    pkt_bytes.delete();

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: set_thresholds(16'd0, 16'd0);
        1: set_thresholds(16'($urandom_range(0, 60)), 16'($urandom_range(0, 40)));
        2: set_thresholds(16'hFFFF, 16'($urandom_range(0, 30)));
        default: set_thresholds(16'($urandom_range(0, 40)), 16'hFFFF);
      endcase
      gaps_on = (ph != 0);
      phase_bytes = bytes_accepted;
      phase_pkts = packets_sent;
      while (bytes_accepted - phase_bytes < 230 || packets_sent - phase_pkts < 15) begin
        pkt_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind < 65) begin
          case ($urandom_range(0, 4))
            0, 1: add_text("GET ");
            2, 3: add_text("POST ");
            default: add_text("PUT ");
          endcase
          if ($urandom_range(0, 9) != 0) add_text("/");
          n = $urandom_range(0, 10);
          repeat (n) pkt_bytes.push_back(uri_chars[$urandom_range(0, uri_chars.len() - 1)]);
          case ($urandom_range(0, 9))
            0: add_text(" HTTP");
            1: add_text("HTTP/1.0\r\n");
            default: add_text(" HTTP/1.1\r\n");
          endcase
          if ($urandom_range(0, 2) == 0) add_text("Accept: */*\r\n");
          case ($urandom_range(0, 9))
            0: add_text("X-Id: 7\r\n");
            1: add_text("host: a\r\n");
            default: begin
              add_text("Host: ");
              n = $urandom_range(0, 8);
              repeat (n) pkt_bytes.push_back(uri_chars[$urandom_range(0, uri_chars.len() - 1)]);
              if ($urandom_range(0, 7) != 0) add_text("\r\n");
            end
          endcase
          if ($urandom_range(0, 1) == 0) add_text("\r\n");
          n = $urandom_range(0, 4);
          repeat (n) pkt_bytes.push_back(8'($urandom_range(0, 255)));
          if ($urandom_range(0, 6) == 0) begin
            n = $urandom_range(1, pkt_bytes.size());
            while (pkt_bytes.size() > n) void'(pkt_bytes.pop_back());
          end
        end else if (kind < 85) begin
          n = $urandom_range(1, 30);
          repeat (n) pkt_bytes.push_back(8'($urandom_range(0, 255)));
          case ($urandom_range(0, 3))
            0: add_text(" HTTP/");
            1: add_text("Host: z\r\n");
            default: add_text("");
          endcase
          n = $urandom_range(0, 6);
          repeat (n) pkt_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
          n = $urandom_range(1, 6);
          repeat (n) pkt_bytes.push_back(short_chars[$urandom_range(0, short_chars.len() - 1)]);
        end
        send_packet();
      end

      if (ph == 1) begin
        // Hold off the result side while short packets keep arriving, so the input backs up.
        drain();
        hold_armed = 1'b1;
        gaps_on = 1'b0;
        repeat (40) begin
          pkt_bytes.delete();
          n = $urandom_range(1, 3);
          repeat (n) pkt_bytes.push_back(8'($urandom_range(0, 255)));
          send_packet();
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Covered %0d payload bytes in %0d packets; %0d results checked, %0d with a method,",
             bytes_accepted, packets_sent, results_checked, method_seen);
    $display("%0d with a host value, under several threshold settings and a long result stall.",
             host_seen);
    if (fail_count == 0) begin
      $display("tb_http_request_field_extractor_core: clean");
    end else begin
      $display("%0d mismatches in total.", fail_count);
      $display("tb_http_request_field_extractor_core: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
